// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk; all but HPC_ASSERT_RST are disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define HPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define HPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition that must hold in the cycle after reset is seen
`define HPC_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- src/hpc_pkg.sv -----
// ----------------------------------------------------------------------------
// hpc_pkg
// Widths, constants and register codes of the heading PI controller.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 4;

  localparam int TGT_W   = 9;
  localparam int MEAS_W  = 14;
  localparam int DRIVE_W = 16;
  localparam int ERR_W   = 16;
  localparam int INTEG_W = 20;
  localparam int GAIN_W  = 8;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam int ERR_FRAC = 14;

  typedef enum logic [IDX_W-1:0] {
    REG_KP      = 2'd0,
    REG_KI_CODE = 2'd1,
    REG_OUT_MAX = 2'd2,
    REG_OUT_MIN = 2'd3
  } reg_idx_t;

  localparam logic signed [DRIVE_W-1:0] OUT_MAX_RST = 16'sd100;
  localparam logic signed [DRIVE_W-1:0] OUT_MIN_RST = -16'sd100;

  localparam logic signed [ERR_W-1:0] ERR_POS_SAT    = 16'sh7FFF;
  localparam logic signed [ERR_W-1:0] ERR_NEG_SAT    = 16'sh8000;
  localparam logic signed [ERR_W-1:0] ERR_WINDOW     = 16'sd2785;
  localparam logic signed [ERR_W-1:0] ERR_WINDOW_NEG = -16'sd2785;

  localparam logic signed [INTEG_W-1:0] INTEG_LIMIT     = 20'sd163840;
  localparam logic signed [INTEG_W-1:0] INTEG_LIMIT_NEG = -20'sd163840;

  // error: |diff| * 2^14 / 180 computed as (x/4) / 45 by reciprocal
  localparam int NUM_W      = 23;
  localparam int NUM4_W     = 21;
  localparam int ERRQ_W     = 15;
  localparam int DIV45_W    = 22;
  localparam int PROD45_W   = NUM4_W + DIV45_W;
  localparam int DIV45_SHIFT = 27;
  localparam logic [DIV45_W-1:0] DIV45_MUL = 22'd2982617;

  // drive: |num| / (255 * 2^14) as (x >> 14) / 255 by reciprocal
  localparam int P1_W       = GAIN_W + 1 + ERR_W;
  localparam int P2_W       = GAIN_W + 1 + INTEG_W;
  localparam int SUM_W      = 34;
  localparam int MAG_W      = 18;
  localparam int DIV255_W   = 19;
  localparam int PROD255_W  = MAG_W + DIV255_W;
  localparam int DIV255_SHIFT = 26;
  localparam int QUOT_W     = 10;
  localparam logic [DIV255_W-1:0] DIV255_MUL = 19'd263173;

endpackage

// ----- src/heading_pi_controller_top.sv -----
// ----------------------------------------------------------------------------
// heading_pi_controller_top
// Heading PI controller: wrapped yaw error, windowed integral, clamped drive.
// ----------------------------------------------------------------------------
// Seven register stages, two reciprocal multiplies.
// Throughput: one word per cycle unless the output stalls on out_ready.
// The integral register is updated once per word in stage 3, in order.
// Reset clears all valid flags, the integral and the gains; clamps go to +/-100.
// ----------------------------------------------------------------------------
module heading_pi_controller_top #(
  parameter int ANGLE_FRAC_BITS = hpc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [hpc_pkg::IDX_W-1:0]            wr_index,
  input  logic [hpc_pkg::CFG_W-1:0]            wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hpc_pkg::TGT_W-1:0]            target_yaw,
  input  logic signed [hpc_pkg::MEAS_W-1:0]    measured_yaw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hpc_pkg::DRIVE_W-1:0]   drive
);

  localparam int TGT_SW    = hpc_pkg::TGT_W + ANGLE_FRAC_BITS;
  localparam int DIFF_W    = ((TGT_SW > hpc_pkg::MEAS_W) ? TGT_SW : hpc_pkg::MEAS_W) + 2;
  localparam int NUM_SHIFT = hpc_pkg::ERR_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [DIFF_W-1:0]        SAT_MAG   = DIFF_W'(360 << ANGLE_FRAC_BITS);

  // configuration
  logic [hpc_pkg::GAIN_W-1:0]          kp;
  logic [hpc_pkg::GAIN_W-1:0]          ki_code;
  logic signed [hpc_pkg::DRIVE_W-1:0]  out_max;
  logic signed [hpc_pkg::DRIVE_W-1:0]  out_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp      <= '0;
      ki_code <= '0;
      out_max <= hpc_pkg::OUT_MAX_RST;
      out_min <= hpc_pkg::OUT_MIN_RST;
    end else if (wr_en) begin
      unique case (hpc_pkg::reg_idx_t'(wr_index))
        hpc_pkg::REG_KP:      kp      <= wr_data[hpc_pkg::GAIN_W-1:0];
        hpc_pkg::REG_KI_CODE: ki_code <= wr_data[hpc_pkg::GAIN_W-1:0];
        hpc_pkg::REG_OUT_MAX: out_max <= signed'(wr_data);
        hpc_pkg::REG_OUT_MIN: out_min <= signed'(wr_data);
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic v0, v1, v2, v3, v4, v5;
  logic en0, en1, en2, en3, en4, en5, en_out;

  assign en_out   = !out_valid || out_ready;
  assign en5      = !v5 || en_out;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en0)    v0        <= in_valid;
      if (en1)    v1        <= v0;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en5)    v5        <= v4;
      if (en_out) out_valid <= v5;
    end
  end

  // stage 0: input word
  logic [hpc_pkg::TGT_W-1:0]          tgt0;
  logic signed [hpc_pkg::MEAS_W-1:0]  meas0;

  always_ff @(posedge clk) begin
    if (en0) begin
      tgt0  <= target_yaw;
      meas0 <= measured_yaw;
    end
  end

  // stage A: wrapped difference, magnitude, numerator
  logic signed [DIFF_W-1:0]        tgt_sc, meas_x, diff_a, diff_w;
  logic [DIFF_W-1:0]               mag_a;
  logic                            neg_a, sat_a;
  logic [hpc_pkg::NUM_W-1:0]       num_a;

  always_comb begin
    tgt_sc = signed'(DIFF_W'(tgt0) << ANGLE_FRAC_BITS);
    meas_x = DIFF_W'(meas0);
    diff_a = tgt_sc - meas_x;
    priority if (diff_a < -HALF_TURN) begin
      diff_w = diff_a + FULL_TURN;
    end else if (diff_a > HALF_TURN) begin
      diff_w = diff_a - FULL_TURN;
    end else begin
      diff_w = diff_a;
    end
    neg_a = diff_w[DIFF_W-1];
    mag_a = neg_a ? unsigned'(-diff_w) : unsigned'(diff_w);
    sat_a = (mag_a >= SAT_MAG);
    num_a = hpc_pkg::NUM_W'(mag_a) << NUM_SHIFT;
  end

  logic [hpc_pkg::NUM4_W-1:0] n4_1;
  logic                       neg1, sat1;

  always_ff @(posedge clk) begin
    if (en1) begin
      n4_1 <= num_a[hpc_pkg::NUM_W-1:2];
      neg1 <= neg_a;
      sat1 <= sat_a;
    end
  end

  // stage B: divide by 45, sign and saturate
  logic [hpc_pkg::PROD45_W-1:0]        prod_b;
  logic [hpc_pkg::ERRQ_W-1:0]          q_b;
  logic signed [hpc_pkg::ERR_W-1:0]    qs_b, err_b;

  always_comb begin
    prod_b = hpc_pkg::PROD45_W'(n4_1) * hpc_pkg::PROD45_W'(hpc_pkg::DIV45_MUL);
    q_b    = prod_b[hpc_pkg::DIV45_SHIFT +: hpc_pkg::ERRQ_W];
    qs_b   = signed'({1'b0, q_b});
    priority if (sat1) begin
      err_b = neg1 ? hpc_pkg::ERR_NEG_SAT : hpc_pkg::ERR_POS_SAT;
    end else begin
      err_b = neg1 ? -qs_b : qs_b;
    end
  end

  logic signed [hpc_pkg::ERR_W-1:0] err2;

  always_ff @(posedge clk) begin
    if (en2) begin
      err2 <= err_b;
    end
  end

  // stage C: integral clamp, window, accumulate
  logic signed [hpc_pkg::INTEG_W-1:0] integral_sum, integral_sum_next, integ_clamp;
  logic                               in_win;

  always_comb begin
    priority if (integral_sum > hpc_pkg::INTEG_LIMIT) begin
      integ_clamp = hpc_pkg::INTEG_LIMIT;
    end else if (integral_sum < hpc_pkg::INTEG_LIMIT_NEG) begin
      integ_clamp = hpc_pkg::INTEG_LIMIT_NEG;
    end else begin
      integ_clamp = integral_sum;
    end
    in_win = (err2 >= hpc_pkg::ERR_WINDOW_NEG) && (err2 <= hpc_pkg::ERR_WINDOW);
    integral_sum_next = in_win ? integ_clamp + hpc_pkg::INTEG_W'(err2) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (en3 && v2) begin
      integral_sum <= integral_sum_next;
    end
  end

  logic signed [hpc_pkg::ERR_W-1:0]   err3;
  logic signed [hpc_pkg::INTEG_W-1:0] integ3;

  always_ff @(posedge clk) begin
    if (en3) begin
      err3   <= err2;
      integ3 <= integral_sum_next;
    end
  end

  // stage D: gain products
  logic signed [hpc_pkg::P1_W-1:0] p1_d;
  logic signed [hpc_pkg::P2_W-1:0] p2_d;

  assign p1_d = $signed({1'b0, kp}) * err3;
  assign p2_d = $signed({1'b0, ki_code}) * integ3;

  logic signed [hpc_pkg::P1_W-1:0] p1_4;
  logic signed [hpc_pkg::P2_W-1:0] p2_4;

  always_ff @(posedge clk) begin
    if (en4) begin
      p1_4 <= p1_d;
      p2_4 <= p2_d;
    end
  end

  // stage E: 255*p1 + p2, magnitude scaled by 2^-14
  logic signed [hpc_pkg::SUM_W-1:0] sum_e, abs_e;
  logic                             neg_e;

  always_comb begin
    sum_e = (hpc_pkg::SUM_W'(p1_4) <<< 8) - hpc_pkg::SUM_W'(p1_4) + hpc_pkg::SUM_W'(p2_4);
    neg_e = sum_e[hpc_pkg::SUM_W-1];
    abs_e = neg_e ? -sum_e : sum_e;
  end

  logic [hpc_pkg::MAG_W-1:0] mag5;
  logic                      neg5;

  always_ff @(posedge clk) begin
    if (en5) begin
      mag5 <= abs_e[hpc_pkg::ERR_FRAC +: hpc_pkg::MAG_W];
      neg5 <= neg_e;
    end
  end

  // stage F: divide by 255, sign, clamp
  logic [hpc_pkg::PROD255_W-1:0]        prod_f;
  logic [hpc_pkg::QUOT_W-1:0]           q_f;
  logic signed [hpc_pkg::DRIVE_W-1:0]   qs_f, dq_f, hi_f, drive_f;

  always_comb begin
    prod_f = hpc_pkg::PROD255_W'(mag5) * hpc_pkg::PROD255_W'(hpc_pkg::DIV255_MUL);
    q_f    = prod_f[hpc_pkg::DIV255_SHIFT +: hpc_pkg::QUOT_W];
    qs_f   = signed'(hpc_pkg::DRIVE_W'(q_f));
    dq_f   = neg5 ? -qs_f : qs_f;
    hi_f   = (dq_f > out_max) ? out_max : dq_f;
    drive_f = (hi_f < out_min) ? out_min : hi_f;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      drive <= drive_f;
    end
  end

endmodule

// ----- src/hpc_checker.sv -----
// ----------------------------------------------------------------------------
// hpc_checker
// Port-level checks of the heading PI controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [hpc_pkg::DRIVE_W-1:0] drive
);

  `HPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")
  `HPC_ASSERT_NXT(a_drive_hold, out_valid && !out_ready, $stable(drive), "drive changed while stalled")
  `HPC_ASSERT_IMP(a_flow_ready, !out_valid || out_ready, in_ready, "pipeline blocked with free output")
  `HPC_ASSERT_RST(a_reset_empty, !out_valid, "output word present after reset")

endmodule

bind heading_pi_controller_top hpc_checker u_hpc_checker (.*);
